// ===== design/mpc_pkg.sv =====
package mpc_pkg;

    localparam int unsigned KEY_W = 64;

    // Multiplier of the index hash; only its low bits reach the index.
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req_type;

    typedef enum logic {
        ST_RUN,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] class_key;
        logic [KEY_W-1:0] selector_key;
        logic [KEY_W-1:0] impl;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

// ===== design/mpc_if.sv =====
interface mpc_req_if import mpc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [KEY_W-1:0] class_key;
    logic [KEY_W-1:0] selector_key;
    logic [KEY_W-1:0] impl_value;

    modport source (
        output valid, req_type, class_key, selector_key, impl_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, class_key, selector_key, impl_value,
        output ready
    );
endinterface

interface mpc_rsp_if import mpc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [KEY_W-1:0] impl_out;

    modport source (
        output valid, found, impl_out,
        input  ready
    );
    modport sink (
        input  valid, found, impl_out,
        output ready
    );
endinterface

// ===== design/mpc_ram.sv =====
module mpc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/method_pointer_cache_top.sv =====
// Channel | Dir | Payload                                         | Role
// i_req   | in  | req_type, class_key, selector_key, impl_value   | lookup / insert / flush
// o_rsp   | out | found, impl_out                                 | one response per request
//
// Lookups and inserts are taken one per cycle while o_rsp is not stalled; the RAM read is
// registered on the accepting edge and the compare fills the next cycle, so each response
// lands in the output register when the lookup stage advances and is offered on o_rsp from there.
// A flush blocks i_req while a clearing pass walks the RAM, one entry per cycle;
// the same pass runs after reset.
// Reset is synchronous, active low. A stalled o_rsp holds the output register and
// the pending lookup stage; i_req is held off until the stage can advance.
module method_pointer_cache_top import mpc_pkg::*; #(
    parameter int unsigned INDEX_BITS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpc_req_if.sink     i_req,
    mpc_rsp_if.source   o_rsp
);

    localparam int unsigned DEPTH = 1 << INDEX_BITS;
    localparam logic [INDEX_BITS-1:0] HASH_LOW = HASH_MULT[INDEX_BITS-1:0];

    t_state r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_idx;

    // lookup stage: holds the request while the RAM read data is registered
    logic             r_s1_valid;
    logic             r_s1_lookup;
    logic [KEY_W-1:0] r_s1_class;
    logic [KEY_W-1:0] r_s1_sel;

    // output register
    logic             r_out_valid;
    logic             r_out_found;
    logic [KEY_W-1:0] r_out_impl;

    t_req_type               req_type;
    logic                    in_ready, in_acc, out_adv, s1_adv, hit;
    logic [2*INDEX_BITS-1:0] prod;
    logic [INDEX_BITS-1:0]   idx;
    logic                    clearing, clr_done;
    logic                    mem_we, mem_re;
    logic [INDEX_BITS-1:0]   mem_waddr;
    t_entry                  mem_wdata, rd_entry;
    logic [ENTRY_W-1:0]      rd_bits;

    assign req_type = t_req_type'(i_req.req_type);

    // Only the low index bits of the product survive, so multiply narrow.
    assign prod = i_req.class_key[INDEX_BITS-1:0] * HASH_LOW;
    assign idx  = prod[INDEX_BITS-1:0] + i_req.selector_key[INDEX_BITS-1:0];

    assign out_adv  = !r_out_valid || o_rsp.ready;
    assign s1_adv   = r_s1_valid && out_adv;
    assign in_ready = (r_state == ST_RUN) && (!r_s1_valid || out_adv);
    assign in_acc   = i_req.valid && in_ready;
    assign clr_done = (r_clr_idx == {INDEX_BITS{1'b1}});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (in_acc && req_type == REQ_FLUSH) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (clr_done) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // RAM control: clearing pass owns the write port; inserts write on accept
    always_comb begin
        clearing  = (r_state == ST_CLEAR);
        mem_we    = 1'b0;
        mem_waddr = idx;
        mem_wdata = '0;
        mem_re    = in_acc && (req_type == REQ_LOOKUP);
        if (clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
        end else if (in_acc && req_type == REQ_INSERT) begin
            mem_we                 = 1'b1;
            mem_wdata.valid        = 1'b1;
            mem_wdata.class_key    = i_req.class_key;
            mem_wdata.selector_key = i_req.selector_key;
            mem_wdata.impl         = i_req.impl_value;
        end
    end

    mpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (idx),
        .o_rdata (rd_bits)
    );

    assign rd_entry = t_entry'(rd_bits);

    // Hit needs a lookup request, a valid entry, both keys equal and a nonzero pointer.
    assign hit = r_s1_lookup && rd_entry.valid
              && (rd_entry.class_key == r_s1_class)
              && (rd_entry.selector_key == r_s1_sel)
              && (rd_entry.impl != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // advance the clearing pointer; restart it when a flush is taken
            if (clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end else if (in_acc && req_type == REQ_FLUSH) begin
                r_clr_idx <= '0;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_lookup <= (req_type == REQ_LOOKUP);
            r_s1_class  <= i_req.class_key;
            r_s1_sel    <= i_req.selector_key;
        end
        if (s1_adv) begin
            r_out_found <= hit;
            r_out_impl  <= hit ? rd_entry.impl : '0;
        end
    end

    assign i_req.ready    = in_ready;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.impl_out = r_out_impl;

endmodule
